// File: design/assert_macros.svh
// Assertion macros shared by the WAV-to-DAC stream design.
// Included by every RTL file that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at every rising clock edge outside reset.
`define WPD_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("wav parser assertion failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define WPD_ASSERT_NEVER(name, clk, rst, cond) \
  `WPD_ASSERT(name, clk, rst, !(cond))

`else

`define WPD_ASSERT(name, clk, rst, prop)
`define WPD_ASSERT_NEVER(name, clk, rst, cond)

`endif

`endif

// File: design/wpd_pkg.sv
// Package for the WAV-to-DAC stream unit: parser phases, RIFF tags,
// result kinds and the item/result structs passed between stages.
// No dependencies.
package wpd_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_RSIZE = 3'd1;
  localparam logic [2:0] PH_WAVE  = 3'd2;
  localparam logic [2:0] PH_CHUNK = 3'd3;
  localparam logic [2:0] PH_FMT   = 3'd4;
  localparam logic [2:0] PH_SKIP  = 3'd5;
  localparam logic [2:0] PH_DATA  = 3'd6;
  localparam logic [2:0] PH_DRAIN = 3'd7;

  // Little-endian four-character tags
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Header field values that the data chunk checks against, and the fmt body size
  localparam logic [15:0] FMT_PCM    = 16'd1;
  localparam logic [15:0] CH_MONO    = 16'd1;
  localparam logic [15:0] CH_STEREO  = 16'd2;
  localparam logic [15:0] BITS_8     = 16'd8;
  localparam logic [15:0] BITS_16    = 16'd16;
  localparam logic [31:0] FMT_BODY   = 32'd16;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_EARLY  = 2'd3;

  // One buffered input byte
  typedef struct packed {
    logic       vld;
    logic [7:0] data_byte;
    logic       end_of_file;
  } wpd_item_t;

  // One result request from the parser
  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [7:0]  dac_code;
    logic        final_res;
    logic [31:0] play_rate;
    logic        stereo;
  } wpd_result_t;

endpackage

// File: design/wav_pcm_to_dac_stream_unit.sv
// WAV byte-stream parser that turns PCM samples into 8-bit DAC codes.
// Top level; uses wpd_pkg, wpd_in_reg, wpd_parser and wpd_out_reg.
//
// Input channel (in_valid / in_stall) carries one file byte per request,
// with end_of_file marking the last byte of a file. The parser checks the
// RIFF and WAVE tags, walks the chunks, reads the fmt chunk and validates
// the header at the data chunk, reporting accept (with rate and stereo
// flag) or reject. Each sample frame then gives one DAC code request.
// Output channel (out_valid / out_stall) carries at most one result per
// input byte; bytes that give no result produce nothing on it.
// A result passes through the input register and then the result register,
// where it is presented until the receiver takes it.
// Throughput: one byte per cycle while the receiver does not stall, set by the parser updating its state once per byte.
// When the receiver stalls, the result register holds; the held input byte
// waits behind it and in_stall rises, so nothing is lost or repeated.
// Reset empties both registers and returns the parser to expecting RIFF;
// the last byte of each file also returns it there.
module wav_pcm_to_dac_stream_unit
  import wpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  dac_code,
  output logic        final_res,
  output logic [31:0] play_rate,
  output logic        stereo
);

  wpd_item_t   item;
  wpd_result_t res;
  logic        out_free;
  logic        adv;

  // Move the held byte through the parser whenever the result slot is free
  assign adv = item.vld && out_free;

  wpd_in_reg u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .adv         (adv),
    .item        (item)
  );

  wpd_parser u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .item (item),
    .res  (res)
  );

  wpd_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .dac_code    (dac_code),
    .final_res   (final_res),
    .play_rate   (play_rate),
    .stereo      (stereo)
  );

endmodule

// File: design/wpd_in_reg.sv
// Input register of the WAV-to-DAC stream unit.
// Holds one byte request until the parser takes it; uses wpd_pkg.
module wpd_in_reg
  import wpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  input  logic       adv,
  output wpd_item_t  item
);

  logic       vld;
  logic [7:0] byte_hold;
  logic       eof_hold;
  logic       take;

  // Stall only while a held request cannot move on this cycle
  assign in_stall = vld && !adv;
  assign take     = in_valid && !in_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= 1'b1;
    end else if (adv) begin
      vld <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_hold <= data_byte;
      eof_hold  <= end_of_file;
    end
  end

  assign item = '{vld: vld, data_byte: byte_hold, end_of_file: eof_hold};

endmodule

// File: design/wpd_parser.sv
// RIFF/WAVE chunk parser and PCM-to-DAC sample conversion.
// One byte per step; uses wpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wpd_parser
  import wpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  wpd_item_t   item,
  output wpd_result_t res
);

  logic [2:0]  phase,          phase_next;
  logic [3:0]  idx,            idx_next;
  logic [31:0] chunk_tag,      chunk_tag_next;
  logic [31:0] chunk_length,   chunk_length_next;
  logic [32:0] skip_remaining, skip_remaining_next;
  logic [15:0] format_code,    format_code_next;
  logic [15:0] channel_count,  channel_count_next;
  logic [15:0] sample_width,   sample_width_next;
  logic [31:0] rate_value,     rate_value_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [23:0] partial_sample, partial_sample_next;

  logic [31:0] byte_at;
  logic [31:0] tag_ins;
  logic [31:0] len_ins;
  logic [31:0] frame;
  logic [31:0] data_dec;
  logic [32:0] skip_dec;
  logic        wide;
  logic        two;
  logic [1:0]  last_idx;
  logic        hdr_ok;
  logic [16:0] wsum;
  logic [16:0] wsum_adj;
  logic [15:0] wval;
  logic [8:0]  nsum;
  logic [7:0]  code;

  // Byte placed at its little-endian lane
  assign byte_at  = {24'b0, item.data_byte} << {idx[1:0], 3'b000};
  assign tag_ins  = chunk_tag | byte_at;
  assign len_ins  = chunk_length | byte_at;
  assign frame    = {8'b0, partial_sample} | byte_at;
  assign data_dec = (data_remaining != 32'd0) ? data_remaining - 32'd1 : 32'd0;
  assign skip_dec = (skip_remaining != 33'd0) ? skip_remaining - 33'd1 : 33'd0;

  assign wide     = (sample_width == BITS_16);
  assign two      = (channel_count == CH_STEREO);
  assign last_idx = {wide & two, wide | two};

  // Format checks; the data size is checked on its completed value below
  assign hdr_ok = (format_code == FMT_PCM) && (rate_value != 32'd0) &&
                  ((channel_count == CH_MONO) || (channel_count == CH_STEREO)) &&
                  ((sample_width == BITS_8) || (sample_width == BITS_16));

  // Convert a completed frame: stereo average truncates toward zero
  always_comb begin
    wsum     = {frame[15], frame[15:0]} + {frame[31], frame[31:16]};
    wsum_adj = wsum + {16'b0, wsum[16]};
    wval     = two ? wsum_adj[16:1] : frame[15:0];
    nsum     = {1'b0, frame[7:0]} + {1'b0, frame[15:8]};
    if (wide) begin
      code = {~wval[15], wval[14:8]};
    end else if (two) begin
      code = nsum[8:1];
    end else begin
      code = frame[7:0];
    end
  end

  // Advance the parser by one byte
  always_comb begin
    phase_next           = phase;
    idx_next             = idx;
    chunk_tag_next       = chunk_tag;
    chunk_length_next    = chunk_length;
    skip_remaining_next  = skip_remaining;
    format_code_next     = format_code;
    channel_count_next   = channel_count;
    sample_width_next    = sample_width;
    rate_value_next      = rate_value;
    data_remaining_next  = data_remaining;
    partial_sample_next  = partial_sample;
    res                  = '0;

    if (step) begin
      unique case (phase)
        PH_RIFF, PH_WAVE: begin
          chunk_tag_next = tag_ins;
          idx_next       = idx + 4'd1;
          if (idx[1:0] == 2'd3) begin
            if (tag_ins != ((phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
              res.vld    = 1'b1;
              res.kind   = KIND_REJECT;
              phase_next = PH_DRAIN;
            end else begin
              phase_next = (phase == PH_RIFF) ? PH_RSIZE : PH_CHUNK;
            end
            idx_next       = 4'd0;
            chunk_tag_next = 32'd0;
          end
        end
        PH_RSIZE: begin
          idx_next = idx + 4'd1;
          if (idx[1:0] == 2'd3) begin
            idx_next   = 4'd0;
            phase_next = PH_WAVE;
          end
        end
        PH_CHUNK: begin
          idx_next = idx + 4'd1;
          if (!idx[2]) begin
            chunk_tag_next = tag_ins;
          end else begin
            chunk_length_next = len_ins;
          end
          if (idx[2:0] == 3'd7) begin
            idx_next          = 4'd0;
            chunk_tag_next    = 32'd0;
            chunk_length_next = 32'd0;
            if (chunk_tag == TAG_FMT) begin
              skip_remaining_next = (len_ins > FMT_BODY) ?
                                    {1'b0, len_ins - FMT_BODY} : 33'd0;
              phase_next          = PH_FMT;
            end else if (chunk_tag == TAG_DATA) begin
              res.vld = 1'b1;
              if (hdr_ok && (len_ins != 32'd0)) begin
                res.kind            = KIND_ACCEPT;
                res.play_rate       = rate_value;
                res.stereo          = two;
                data_remaining_next = len_ins;
                partial_sample_next = 24'd0;
                phase_next          = PH_DATA;
              end else begin
                res.kind   = KIND_REJECT;
                phase_next = PH_DRAIN;
              end
            end else begin
              skip_remaining_next = {1'b0, len_ins} + {32'b0, len_ins[0]};
              phase_next = (len_ins != 32'd0) ? PH_SKIP : PH_CHUNK;
            end
          end
        end
        PH_FMT: begin
          unique case (idx)
            4'd0:    format_code_next     = {8'b0, item.data_byte};
            4'd1:    format_code_next     = {item.data_byte, format_code[7:0]};
            4'd2:    channel_count_next   = {8'b0, item.data_byte};
            4'd3:    channel_count_next   = {item.data_byte, channel_count[7:0]};
            4'd4:    rate_value_next      = {24'b0, item.data_byte};
            4'd5, 4'd6, 4'd7: rate_value_next = rate_value | byte_at;
            4'd14:   sample_width_next    = {8'b0, item.data_byte};
            4'd15:   sample_width_next    = {item.data_byte, sample_width[7:0]};
            default: ;
          endcase
          idx_next = idx + 4'd1;
          if (idx == 4'd15) begin
            idx_next   = 4'd0;
            phase_next = (skip_remaining != 33'd0) ? PH_SKIP : PH_CHUNK;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 33'd0) begin
            phase_next = PH_CHUNK;
          end
        end
        PH_DATA: begin
          data_remaining_next = data_dec;
          if (idx < {2'b00, last_idx}) begin
            partial_sample_next = partial_sample | byte_at[23:0];
            idx_next            = idx + 4'd1;
          end else begin
            res.vld             = 1'b1;
            res.kind            = KIND_SAMPLE;
            res.dac_code        = code;
            res.final_res       = (data_dec == 32'd0) || item.end_of_file;
            idx_next            = 4'd0;
            partial_sample_next = 24'd0;
            if (data_dec == 32'd0) begin
              phase_next = PH_DRAIN;
            end
          end
        end
        default: ;
      endcase

      // Last byte of the file: flag an unfinished header or frame, then restart
      if (item.end_of_file) begin
        if (!res.vld && ((phase_next <= PH_SKIP) ||
                         ((phase_next == PH_DATA) && (idx_next != 4'd0)))) begin
          res.vld  = 1'b1;
          res.kind = KIND_EARLY;
        end
        phase_next           = PH_RIFF;
        idx_next             = 4'd0;
        chunk_tag_next       = 32'd0;
        chunk_length_next    = 32'd0;
        skip_remaining_next  = 33'd0;
        format_code_next     = 16'd0;
        channel_count_next   = 16'd0;
        sample_width_next    = 16'd0;
        rate_value_next      = 32'd0;
        data_remaining_next  = 32'd0;
        partial_sample_next  = 24'd0;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF;
      idx             <= 4'd0;
      chunk_tag       <= 32'd0;
      chunk_length    <= 32'd0;
      skip_remaining  <= 33'd0;
      format_code     <= 16'd0;
      channel_count   <= 16'd0;
      sample_width    <= 16'd0;
      rate_value      <= 32'd0;
      data_remaining  <= 32'd0;
      partial_sample  <= 24'd0;
    end else begin
      phase           <= phase_next;
      idx             <= idx_next;
      chunk_tag       <= chunk_tag_next;
      chunk_length    <= chunk_length_next;
      skip_remaining  <= skip_remaining_next;
      format_code     <= format_code_next;
      channel_count   <= channel_count_next;
      sample_width    <= sample_width_next;
      rate_value      <= rate_value_next;
      data_remaining  <= data_remaining_next;
      partial_sample  <= partial_sample_next;
    end
  end

  // A partly assembled frame exists only while reading samples
  `WPD_ASSERT(a_partial_only_in_data, clk, rst, (phase != PH_DATA) |-> (partial_sample == 24'd0))
  // The byte position never passes the last byte of a frame
  `WPD_ASSERT(a_frame_index_bound, clk, rst, (phase == PH_DATA) |-> (idx <= {2'b00, last_idx}))
  // Skipping always has bytes left to skip
  `WPD_ASSERT_NEVER(a_skip_nonzero, clk, rst, (phase == PH_SKIP) && (skip_remaining == 33'd0))
  // An accepted header moves into sample reading unless the file ends
  `WPD_ASSERT(a_accept_enters_data, clk, rst, (step && res.vld && (res.kind == KIND_ACCEPT) && !item.end_of_file) |=> (phase == PH_DATA))

endmodule

// File: design/wpd_out_reg.sv
// Output register of the WAV-to-DAC stream unit.
// Holds one result request until the receiver takes it; uses wpd_pkg.
module wpd_out_reg
  import wpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  wpd_result_t res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  dac_code,
  output logic        final_res,
  output logic [31:0] play_rate,
  output logic        stereo
);

  logic        load;
  wpd_result_t hold;

  // Free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign load     = adv && res.vld;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (out_free && load) begin
      hold <= res;
    end
  end

  assign kind        = hold.kind;
  assign dac_code    = hold.dac_code;
  assign final_res   = hold.final_res;
  assign play_rate   = hold.play_rate;
  assign stereo      = hold.stereo;

endmodule
